### hw/rtl/mfqd_pkg.sv
`default_nettype none
package mfqd_pkg;

  localparam int ID_BITS            = 10;
  localparam int QUEUE_DEPTH_DEF    = 64;
  localparam int NUM_LEVELS_DEF     = 4;
  localparam int TIME_W             = 32;
  localparam int JT_W               = 16;
  localparam int Q_W                = 8;
  localparam int STAT_W             = 3;

  // command codes (in_tuser)
  localparam logic CMD_ARRIVE   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // result status codes (out_tuser)
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_RAN      = 3'd2;
  localparam logic [STAT_W-1:0] ST_IDLE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_RAN_LOST = 3'd4;

  typedef struct packed {
    logic            started;
    logic [JT_W-1:0] remaining;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic take_arrive;
    logic take_dispatch;
    logic complete;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/multilevel_feedback_queue_dispatch.sv
// Flow: item accepted in S_IDLE, then completed in S_WORK and registered with out_tvalid high.
// One item in flight: a new item is taken only once the last one completes; out_tready stalls delay it.
// The pace is set by the single queue memory: registered read in the accept cycle,
// tail write-back of a demoted job in the completing S_WORK cycle.
// Reset (rst_n low, synchronous): pointers, counts, time and output valid clear, quantum = 1;
// the queue memory itself is not cleared and needs no clearing pass.
`default_nettype none
module multilevel_feedback_queue_dispatch #(
  parameter int QUEUE_DEPTH = mfqd_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_LEVELS  = mfqd_pkg::NUM_LEVELS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire                          in_tuser,     // [0] command
  input  wire  [31:0]                  in_tdata,     // job_id[9:0], job_level[11:10], job_time[27:12]
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [mfqd_pkg::STAT_W-1:0]  out_tuser,    // [2:0] status
  output logic [63:0]                  out_tdata,    // served_id[9:0], served_level[11:10],
                                                     // slot_length[27:12], finished[28],
                                                     // first_run[29], start_time[61:30]
  input  wire                          cfg_wr_en,
  input  wire  [mfqd_pkg::Q_W-1:0]     cfg_wr_data   // quantum
);
  import mfqd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;
  logic       unused_pad;

  assign unused_pad = ^in_tdata[31:28];

  mfqd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mfqd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .job_id      (in_tdata[9:0]),
    .job_level   (in_tdata[11:10]),
    .job_time    (in_tdata[27:12]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous one in flight");

  // a fresh result only appears while the input is busy or right after an accept
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && !unused_pad) || ($rose(out_tvalid) && unused_pad)
      |-> $past(in_tvalid && in_tready, 1) || $past(!in_tready, 1))
    else $error("result without accepted item");

  // idle slots name no job
  a_idle_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_IDLE) |-> (out_tdata[11:0] == '0 && out_tdata[29:28] == '0))
    else $error("idle result carries job fields");

  // an arrive result carries only its status
  a_arrive_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_ACCEPTED || out_tuser == ST_DROPPED)) |-> (out_tdata == '0))
    else $error("arrive result carries payload");

endmodule
`default_nettype wire

### hw/rtl/mfqd_ctrl.sv
`default_nettype none
module mfqd_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire                   in_cmd,
  output logic                  in_tready,
  input  wire                   out_tready,
  input  mfqd_pkg::dp_status_t  stat_i,
  output mfqd_pkg::ctrl_cmd_t   cmd_o
);
  import mfqd_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.take_arrive   = (in_cmd == CMD_ARRIVE);
          cmd_o.take_dispatch = (in_cmd == CMD_DISPATCH);
          state_nxt           = S_WORK;
        end
      end
      S_WORK: begin
        // finish once the output register is free or draining
        if (!stat_i.out_valid || out_tready) begin
          cmd_o.complete = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mfqd_dp.sv
`default_nettype none
module mfqd_dp #(
  parameter int QUEUE_DEPTH = mfqd_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_LEVELS  = mfqd_pkg::NUM_LEVELS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  mfqd_pkg::ctrl_cmd_t              cmd_i,
  output mfqd_pkg::dp_status_t             stat_o,
  input  wire [mfqd_pkg::ID_BITS-1:0]      job_id,
  input  wire [1:0]                        job_level,
  input  wire [mfqd_pkg::JT_W-1:0]         job_time,
  input  wire                              cfg_wr_en,
  input  wire [mfqd_pkg::Q_W-1:0]          cfg_wr_data,
  input  wire                              out_tready,
  output logic                             out_tvalid,
  output logic [mfqd_pkg::STAT_W-1:0]      out_tuser,
  output logic [63:0]                      out_tdata
);
  import mfqd_pkg::*;

  localparam int LW        = $clog2(NUM_LEVELS);
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int AW        = LW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  entry_t         mem [0:MEM_DEPTH-1];
  entry_t         rd_r;

  logic [PW-1:0]  head_r [NUM_LEVELS];
  logic [PW-1:0]  head_nxt [NUM_LEVELS];
  logic [PW-1:0]  tail_r [NUM_LEVELS];
  logic [PW-1:0]  tail_nxt [NUM_LEVELS];
  logic [CW-1:0]  cnt_r [NUM_LEVELS];
  logic [CW-1:0]  cnt_nxt [NUM_LEVELS];

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [Q_W-1:0]    quantum_r;
  logic              disp_r, arr_ok_r, found_r;
  logic [LW-1:0]     lvl_r;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [61:0]       out_data_r, out_data_nxt;

  logic [LW-1:0]     arr_lvl, srch_lvl, next_lvl, push_lvl;
  logic              found_c, fin, demote, push_en, pop_en, next_room;
  logic [JT_W-1:0]   slot;
  entry_t            push_data;

  // arrival level, clamped into the last level
  always_comb begin
    if (int'(job_level) >= NUM_LEVELS) begin
      arr_lvl = LAST_LVL;
    end else begin
      arr_lvl = LW'(job_level);
    end
  end

  // first non-empty level, lowest index wins
  always_comb begin
    found_c  = 1'b0;
    srch_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        found_c  = 1'b1;
        srch_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    next_lvl  = (lvl_r == LAST_LVL) ? lvl_r : lvl_r + 1'b1;
    next_room = (cnt_r[next_lvl] != FULL_CNT);
    if (lvl_r == '0) begin
      slot = rd_r.remaining;
      fin  = 1'b1;
    end else begin
      slot = JT_W'(quantum_r);
      fin  = (rd_r.remaining <= JT_W'(quantum_r));
    end
    demote = disp_r && found_r && (lvl_r != '0) && !fin;
  end

  always_comb begin
    push_lvl = cmd_i.take_arrive ? arr_lvl : next_lvl;
    if (cmd_i.take_arrive) begin
      push_data.started   = 1'b0;
      push_data.remaining = job_time;
      push_data.id        = job_id;
    end else begin
      push_data.started   = 1'b1;
      push_data.remaining = rd_r.remaining - JT_W'(quantum_r);
      push_data.id        = rd_r.id;
    end
    push_en = (cmd_i.take_arrive && (cnt_r[arr_lvl] != FULL_CNT)) ||
              (cmd_i.complete && demote && next_room);
    pop_en  = cmd_i.take_dispatch && found_c;
  end

  // pointer and count updates; push and pop never share a cycle
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    if (pop_en) begin
      head_nxt[srch_lvl] = (head_r[srch_lvl] == LAST_PTR) ? '0 : head_r[srch_lvl] + 1'b1;
      cnt_nxt[srch_lvl]  = cnt_r[srch_lvl] - 1'b1;
    end
    if (push_en) begin
      tail_nxt[push_lvl] = (tail_r[push_lvl] == LAST_PTR) ? '0 : tail_r[push_lvl] + 1'b1;
      cnt_nxt[push_lvl]  = cnt_r[push_lvl] + 1'b1;
    end
  end

  always_comb begin
    out_stat_nxt  = out_stat_r;
    out_data_nxt  = out_data_r;
    time_nxt      = time_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (cmd_i.complete) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (!disp_r) begin
        out_stat_nxt = arr_ok_r ? ST_ACCEPTED : ST_DROPPED;
      end else if (!found_r) begin
        out_stat_nxt        = ST_IDLE;
        out_data_nxt[27:12] = JT_W'(quantum_r);
        out_data_nxt[61:30] = time_r;
        time_nxt            = time_r + TIME_W'(quantum_r);
      end else begin
        out_stat_nxt        = (demote && !next_room) ? ST_RAN_LOST : ST_RAN;
        out_data_nxt[9:0]   = rd_r.id;
        out_data_nxt[11:10] = 2'(lvl_r);
        out_data_nxt[27:12] = slot;
        out_data_nxt[28]    = fin;
        out_data_nxt[29]    = !rd_r.started;
        out_data_nxt[61:30] = time_r;
        time_nxt            = time_r + TIME_W'(slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[{push_lvl, tail_r[push_lvl]}] <= push_data;
    end
    if (cmd_i.take_dispatch) begin
      rd_r <= mem[{srch_lvl, head_r[srch_lvl]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take_arrive || cmd_i.take_dispatch) begin
      disp_r   <= cmd_i.take_dispatch;
      arr_ok_r <= (cnt_r[arr_lvl] != FULL_CNT);
      found_r  <= found_c;
      lvl_r    <= srch_lvl;
    end
    out_stat_r <= out_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      time_r      <= '0;
      quantum_r   <= Q_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  assign stat_o.out_valid = out_valid_r;
  assign out_tvalid       = out_valid_r;
  assign out_tuser        = out_stat_r;
  assign out_tdata        = {2'b00, out_data_r};

endmodule
`default_nettype wire
